[design/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants for the monochrome horizontal span fill unit.
// ----------------------------------------------------------------------------
package hsf_pkg;

   localparam int FB_BYTES_DEF  = 4096;

   localparam int ROW_BYTES_W   = 9;
   localparam int X_W           = 11;
   localparam int ROW_W         = 12;
   localparam int ADDR_W        = 12;
   localparam int DATA_W        = 8;
   localparam int BASE_W        = ROW_W + ROW_BYTES_W;
   localparam int SUM_W         = BASE_W + 1;
   localparam int REQ_TDATA_W   = 48;

   localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 9'd16;
   localparam logic [DATA_W-1:0]      BYTE_ONES     = 8'hFF;
   localparam logic [DATA_W-1:0]      BYTE_ZERO     = 8'h00;

   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_ERR = 1'b1;

   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [X_W-1:0]    start_x;
      logic [X_W-1:0]    end_x;
      logic [ROW_W-1:0]  row;
      logic [ADDR_W-1:0] read_address;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              status;
   } result_type;

endpackage

[design/monochrome_horizontal_span_fill_unit.sv]
// ----------------------------------------------------------------------------
// monochrome_horizontal_span_fill_unit
// Horizontal span fill and byte read on a 1-bit-per-pixel frame store.
// ----------------------------------------------------------------------------
// read command: S_MUL, S_CHK, then S_RDD unless out of range; one item at a time
// draw command: S_MUL, S_CHK, S_RD1, S_WR1; across bytes S_FILL (middle bytes),
//   S_RD2, S_WR2; a range error ends at S_CHK; the fill writes one byte per cycle
// result waits in an output register; the next request is taken once it is queued
// reset: row width returns to 16 bytes, then a clearing pass over all FB_BYTES
//   bytes zeroes the frame store while req_tready stays low
module monochrome_horizontal_span_fill_unit
   import hsf_pkg::*;
#(
   parameter int FB_BYTES = FB_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // start_x[10:0], end_x[21:11], row[33:22], read_address[45:34], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // command[0]
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_data[7:0]
   output logic [DATA_W-1:0]      rsp_tdata,
   // status[0]
   output logic [0:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [ROW_BYTES_W-1:0] csr_data
);

   localparam int AW = $clog2(FB_BYTES);

   logic [ROW_BYTES_W-1:0] row_bytes_ff, row_bytes_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_res_ff, rsp_res_in;

   req_type                req;
   logic                   res_valid;
   result_type             res;
   logic                   res_take;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [DATA_W-1:0]      mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [DATA_W-1:0]      mem_rd_data;

   assign req.command      = cmd_type'(req_tuser[0]);
   assign req.start_x      = req_tdata[10:0];
   assign req.end_x        = req_tdata[21:11];
   assign req.row          = req_tdata[33:22];
   assign req.read_address = req_tdata[45:34];

   assign csr_ready  = 1'b1;
   assign res_take   = res_valid && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_res_ff.read_data;
   assign rsp_tuser  = rsp_res_ff.status;

   always_comb begin
      row_bytes_in = row_bytes_ff;
      if (csr_valid && csr_ready) begin
         row_bytes_in = csr_data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_bytes_ff <= row_bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   hsf_seq #(
      .FB_BYTES (FB_BYTES),
      .AW       (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .row_bytes   (row_bytes_ff),
      .req_valid   (req_tvalid),
      .req         (req),
      .req_ready   (req_tready),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   hsf_mem #(
      .DEPTH (FB_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule

[design/hsf_mem.sv]
// ----------------------------------------------------------------------------
// hsf_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hsf_mem
   import hsf_pkg::*;
#(
   parameter int DEPTH = FB_BYTES_DEF,
   parameter int AW    = $clog2(FB_BYTES_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[design/hsf_seq.sv]
// ----------------------------------------------------------------------------
// hsf_seq
// Command sequencer: clearing pass, range checks, byte reads, edge
// read-modify-write and byte-per-cycle fill of the frame store.
// ----------------------------------------------------------------------------
module hsf_seq
   import hsf_pkg::*;
#(
   parameter int FB_BYTES = FB_BYTES_DEF,
   parameter int AW       = $clog2(FB_BYTES_DEF)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ROW_BYTES_W-1:0] row_bytes,
   input  logic                   req_valid,
   input  req_type                req,
   output logic                   req_ready,
   output logic                   res_valid,
   output result_type             res,
   input  logic                   res_take,
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic [DATA_W-1:0]      mem_wr_data,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr,
   input  logic [DATA_W-1:0]      mem_rd_data
);

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_MUL   = 11'b00000000100,
      S_CHK   = 11'b00000001000,
      S_RD1   = 11'b00000010000,
      S_WR1   = 11'b00000100000,
      S_FILL  = 11'b00001000000,
      S_RD2   = 11'b00010000000,
      S_WR2   = 11'b00100000000,
      S_RDD   = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   req_type              req_ff, req_in;
   logic [BASE_W-1:0]    base_ff, base_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        last_ff, last_in;
   logic                 same_ff, same_in;
   logic [DATA_W-1:0]    smask_ff, smask_in;
   logic [DATA_W-1:0]    emask_ff, emask_in;
   result_type           res_ff, res_in;

   logic [7:0]           first_byte;
   logic [7:0]           last_byte;
   logic [SUM_W-1:0]     sum_last;
   logic                 draw_err;
   logic                 read_ok;
   logic [AW-1:0]        ptr_next;

   assign first_byte = req_ff.start_x[X_W-1:3];
   assign last_byte  = req_ff.end_x[X_W-1:3];
   assign sum_last   = {1'b0, base_ff} + SUM_W'(last_byte);
   assign draw_err   = (req_ff.start_x > req_ff.end_x)
                    || ({1'b0, last_byte} >= row_bytes)
                    || (sum_last >= SUM_W'(FB_BYTES));
   assign read_ok    = SUM_W'(req_ff.read_address) < SUM_W'(FB_BYTES);
   assign ptr_next   = ptr_ff + AW'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      req_in      = req_ff;
      base_in     = base_ff;
      ptr_in      = ptr_ff;
      last_in     = last_ff;
      same_in     = same_ff;
      smask_in    = smask_ff;
      emask_in    = emask_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff;
      mem_wr_data = BYTE_ONES;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = BYTE_ZERO;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(FB_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            base_in  = BASE_W'(req_ff.row) * BASE_W'(row_bytes);
            state_in = S_CHK;
         end
         S_CHK: begin
            res_in.read_data = BYTE_ZERO;
            res_in.status    = STAT_OK;
            if (req_ff.command == CMD_READ) begin
               if (read_ok) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = AW'(req_ff.read_address);
                  state_in    = S_RDD;
               end else begin
                  res_in.status = STAT_ERR;
                  state_in      = S_DONE;
               end
            end else if (draw_err) begin
               res_in.status = STAT_ERR;
               state_in      = S_DONE;
            end else begin
               ptr_in   = AW'(base_ff + BASE_W'(first_byte));
               last_in  = AW'(sum_last);
               same_in  = (first_byte == last_byte);
               smask_in = BYTE_ONES >> req_ff.start_x[2:0];
               emask_in = BYTE_ONES << (3'd7 - req_ff.end_x[2:0]);
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            mem_rd_en = 1'b1;
            state_in  = S_WR1;
         end
         S_WR1: begin
            mem_wr_en = 1'b1;
            if (same_ff) begin
               mem_wr_data = mem_rd_data | (smask_ff & emask_ff);
               state_in    = S_DONE;
            end else begin
               mem_wr_data = mem_rd_data | smask_ff;
               ptr_in      = ptr_next;
               state_in    = (ptr_next == last_ff) ? S_RD2 : S_FILL;
            end
         end
         S_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = BYTE_ONES;
            ptr_in      = ptr_next;
            if (ptr_next == last_ff) begin
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            mem_rd_en = 1'b1;
            state_in  = S_WR2;
         end
         S_WR2: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data | emask_ff;
            state_in    = S_DONE;
         end
         S_RDD: begin
            res_in.read_data = mem_rd_data;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      base_ff  <= base_in;
      ptr_ff   <= ptr_in;
      last_ff  <= last_in;
      same_ff  <= same_in;
      smask_ff <= smask_in;
      emask_ff <= emask_in;
      res_ff   <= res_in;
   end

endmodule

[design/hsf_checker.sv]
// ----------------------------------------------------------------------------
// hsf_checker
// Port-level checks for the span fill unit, bound to the top level.
// ----------------------------------------------------------------------------
module hsf_checker
   import hsf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [DATA_W-1:0]      rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // error results carry zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == STAT_ERR) |-> rsp_tdata == BYTE_ZERO)
      else $error("error result with nonzero data");

   // one request in flight: no transfer on the cycle after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on back-to-back cycles");

endmodule

bind monochrome_horizontal_span_fill_unit hsf_checker u_hsf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/monochrome_horizontal_span_fill_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monochrome_horizontal_span_fill_unit_test
// Self-checking bench for the span fill unit. Draw and read commands go in
// on the request stream, and a local copy of the frame store predicts each
// response. Traffic runs under several row widths, including zero and
// widths above 256. Both sides stall at random, and one long output
// hold-off backs the request stream up.
// ----------------------------------------------------------------------------
module monochrome_horizontal_span_fill_unit_test;
   import hsf_pkg::*;

   localparam int          FRAME_BYTES = FB_BYTES_DEF;
   localparam int          FRAME_AW    = $clog2(FRAME_BYTES);
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int          HOLD_CYCLES = 400;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [ROW_BYTES_W-1:0] csr_data   = '0;

   logic [DATA_W-1:0] frame_copy [FRAME_BYTES];
   int unsigned       copy_row_bytes = 32'(ROW_BYTES_RST);
   result_type        awaited_results [$];

   bit          gaps_on      = 1'b1;
   bit          hold_request = 1'b0;
   int          hold_left    = 0;
   int unsigned hot_addr     = 0;
   int unsigned cycle_count  = 0;
   int          failures     = 0;
   int          draws_sent   = 0;
   int          reads_sent   = 0;
   int          rejects_seen = 0;
   int          results_checked = 0;

   monochrome_horizontal_span_fill_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  awaited_results.size());
         $display("monochrome_horizontal_span_fill_unit regression: fail");
         $finish;
      end
   end

   // frame store copy: applies one command and queues its response
   task automatic apply_span_command(input req_type t);
      result_type  r;
      int unsigned first;
      int unsigned last;
      int unsigned base;
      int unsigned shift;
      logic [DATA_W-1:0] smask;
      logic [DATA_W-1:0] emask;
      r.read_data = BYTE_ZERO;
      r.status    = STAT_OK;
      if (t.command == CMD_READ) begin
         reads_sent++;
         if (32'(t.read_address) < FRAME_BYTES)
            r.read_data = frame_copy[t.read_address];
         else
            r.status = STAT_ERR;
      end else begin
         draws_sent++;
         first = 32'(t.start_x[X_W-1:3]);
         last  = 32'(t.end_x[X_W-1:3]);
         base  = 32'(t.row) * copy_row_bytes;
         if (t.start_x > t.end_x || last >= copy_row_bytes || base + last >= FRAME_BYTES) begin
            r.status = STAT_ERR;
         end else begin
            shift = 32'(t.end_x[2:0]);
            smask = BYTE_ONES >> t.start_x[2:0];
            emask = ~(BYTE_ONES >> (shift + 1));
            if (first == last) begin
               frame_copy[FRAME_AW'(base + first)] |= smask & emask;
            end else begin
               frame_copy[FRAME_AW'(base + first)] |= smask;
               for (int unsigned b = first + 1; b < last; b++)
                  frame_copy[FRAME_AW'(base + b)] = BYTE_ONES;
               frame_copy[FRAME_AW'(base + last)] |= emask;
            end
         end
      end
      if (r.status == STAT_ERR)
         rejects_seen++;
      awaited_results.push_back(r);
   endtask

   // request transfers
   always @(posedge clock) begin
      req_type t;
      if (!reset && req_tvalid && req_tready) begin
         t.command      = cmd_type'(req_tuser[0]);
         t.start_x      = req_tdata[10:0];
         t.end_x        = req_tdata[21:11];
         t.row          = req_tdata[33:22];
         t.read_address = req_tdata[45:34];
         apply_span_command(t);
      end
   end

   // response transfers
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: response with none expected, read_data %h status %b",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            e = awaited_results.pop_front();
            results_checked++;
            if (rsp_tdata !== e.read_data) begin
               $display("%0t: read_data mismatch, expected %h actual %h",
                        $time, e.read_data, rsp_tdata);
               failures++;
            end
            if (rsp_tuser[0] !== e.status) begin
               $display("%0t: status mismatch, expected %b actual %b",
                        $time, e.status, rsp_tuser[0]);
               failures++;
            end
         end
      end
   end

   // receiver: random stalls plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(99) < 7) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input req_type t);
      if (gaps_on && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= t.command;
      req_tdata  <= {2'b00, t.read_address, t.row, t.end_x, t.start_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_row_bytes(input int unsigned width);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data  <= ROW_BYTES_W'(width);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      copy_row_bytes = width & 9'h1FF;
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk_req(input cmd_type cmd, input int unsigned sx,
                                      input int unsigned ex, input int unsigned row,
                                      input int unsigned addr);
      req_type t;
      t.command      = cmd;
      t.start_x      = X_W'(sx);
      t.end_x        = X_W'(ex);
      t.row          = ROW_W'(row);
      t.read_address = ADDR_W'(addr);
      return t;
   endfunction

   // span that lies inside the current row width and inside memory
   task automatic shape_span(inout req_type t);
      int unsigned rb;
      int unsigned row;
      int unsigned lim;
      int unsigned first;
      int unsigned last;
      int unsigned sx;
      int unsigned ex;
      int unsigned tmp;
      rb    = copy_row_bytes;
      row   = $urandom_range(0, (FRAME_BYTES - 1) / rb);
      lim   = rb - 1;
      if (lim > FRAME_BYTES - 1 - row * rb)
         lim = FRAME_BYTES - 1 - row * rb;
      if (lim > 255)
         lim = 255;
      first = $urandom_range(0, lim);
      if ($urandom_range(99) < 6)
         last = first + $urandom_range(0, lim);
      else
         last = first + $urandom_range(0, 3);
      if (last > lim)
         last = lim;
      sx = first * 8 + $urandom_range(0, 7);
      ex = last * 8 + $urandom_range(0, 7);
      if (sx > ex) begin
         tmp = sx;
         sx  = ex;
         ex  = tmp;
      end
      t.start_x = X_W'(sx);
      t.end_x   = X_W'(ex);
      t.row     = ROW_W'(row);
      hot_addr  = row * rb + first;
   endtask

   task automatic random_traffic(input int count);
      req_type     t;
      int unsigned pick;
      int          a;
      for (int i = 0; i < count; i++) begin
         pick           = $urandom_range(99);
         t.start_x      = X_W'($urandom);
         t.end_x        = X_W'($urandom);
         t.row          = ROW_W'($urandom);
         t.read_address = ADDR_W'($urandom);
         if (pick < 50) begin
            t.command = CMD_DRAW;
            if (copy_row_bytes != 0)
               shape_span(t);
         end else if (pick < 85) begin
            t.command = CMD_READ;
            if (pick < 72) begin
               a = int'(hot_addr) + int'($urandom_range(0, 6)) - 2;
               if (a < 0)
                  a = 0;
               if (a > FRAME_BYTES - 1)
                  a = FRAME_BYTES - 1;
               t.read_address = ADDR_W'(a);
            end
         end else begin
            t.command = cmd_type'(pick[0]);
         end
         send_item(t);
      end
   endtask

   task automatic test_directed_cases();
      send_item(mk_req(CMD_READ, 0, 0, 0, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 4095));
      send_item(mk_req(CMD_DRAW, 0, 0, 0, 0));
      send_item(mk_req(CMD_DRAW, 7, 7, 0, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 0));
      // both ends in one byte with an aligned start
      send_item(mk_req(CMD_DRAW, 8, 10, 0, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 1));
      send_item(mk_req(CMD_DRAW, 13, 42, 1, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 17));
      send_item(mk_req(CMD_READ, 0, 0, 0, 19));
      send_item(mk_req(CMD_READ, 0, 0, 0, 21));
      send_item(mk_req(CMD_READ, 0, 0, 0, 22));
      // last row, full width
      send_item(mk_req(CMD_DRAW, 0, 127, 255, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 4095));
      send_item(mk_req(CMD_READ, 0, 0, 0, 4080));
      // rejected spans, then a read of row 2 and a valid draw read back in row 3
      send_item(mk_req(CMD_DRAW, 5, 4, 2, 0));
      send_item(mk_req(CMD_DRAW, 0, 128, 2, 0));
      send_item(mk_req(CMD_DRAW, 0, 7, 256, 0));
      send_item(mk_req(CMD_DRAW, 2047, 2047, 4095, 4095));
      send_item(mk_req(CMD_DRAW, 2047, 0, 0, 0));
      send_item(mk_req(CMD_READ, 0, 0, 0, 32));
      send_item(mk_req(CMD_DRAW, 3, 4, 3, 0));
      send_item(mk_req(CMD_READ, 2047, 2047, 4095, 48));
   endtask

   task automatic test_reset_width_traffic();
      random_traffic(220);
   endtask

   task automatic test_output_backpressure();
      wait_drain();
      hold_request = 1'b1;
      random_traffic(40);
   endtask

   task automatic test_narrow_rows();
      set_row_bytes(1);
      random_traffic(220);
   endtask

   task automatic test_full_width_rows();
      set_row_bytes(256);
      random_traffic(160);
   endtask

   task automatic test_oversized_width();
      set_row_bytes(511);
      gaps_on = 1'b0;
      random_traffic(160);
      gaps_on = 1'b1;
   endtask

   task automatic test_zero_width();
      set_row_bytes(0);
      random_traffic(80);
   endtask

   task automatic test_random_width();
      set_row_bytes($urandom_range(2, 255));
      random_traffic(200);
   endtask

   initial begin
      for (int i = 0; i < FRAME_BYTES; i++)
         frame_copy[FRAME_AW'(i)] = BYTE_ZERO;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_reset_width_traffic();
      test_output_backpressure();
      test_narrow_rows();
      test_full_width_rows();
      test_oversized_width();
      test_zero_width();
      test_random_width();
      wait_drain();
      $display("covered %0d draws and %0d reads, %0d rejected, %0d responses checked",
               draws_sent, reads_sent, rejects_seen, results_checked);
      $display("row widths 16, 1, 256, 511, 0 and one random; long output hold-off");
      if (failures == 0)
         $display("monochrome_horizontal_span_fill_unit regression: pass");
      else
         $display("monochrome_horizontal_span_fill_unit regression: fail");
      $finish;
   end

endmodule
